[design/gbag_pkg.sv]
// Shared types, constants and functions of the gray block average to glyph unit.
`timescale 1ns / 1ps

package gbag_pkg;

  // Width of the configuration write data (the widest register).
  localparam int CFG_W = 11;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;
  // Width of one column accumulator.
  localparam int SUM_W = 14;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;

  // ASCII codes of the glyphs, darkest band first.
  localparam logic [6:0] GLYPH_DOT   = 7'd46;
  localparam logic [6:0] GLYPH_COLON = 7'd58;
  localparam logic [6:0] GLYPH_C     = 7'd99;
  localparam logic [6:0] GLYPH_O     = 7'd111;
  localparam logic [6:0] GLYPH_FIVE  = 7'd53;
  localparam logic [6:0] GLYPH_X     = 7'd120;
  localparam logic [6:0] GLYPH_HASH  = 7'd35;
  localparam logic [6:0] GLYPH_AT    = 7'd64;

  // Reciprocal of 100 as 5243 / 2^19; exact floor for sums up to 25500.
  localparam int RECIP_100 = 5243;
  localparam int RECIP_SHIFT = 19;

  // One input pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  // One output glyph.
  typedef struct packed {
    logic [6:0] glyph;
    logic [2:0] level;
    logic       row_end;
  } result_t;

  // Per-item control handed from the position tracker to the accumulator stage.
  typedef struct packed {
    logic       write;
    logic       first;
    logic       emit;
    logic       row_end;
    logic [7:0] gray;
  } stage_t;

  // Luma as floor((30r + 59g + 11b) / 100), using the reciprocal multiply.
  function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [14:0] wsum;
    logic [27:0] prod;
    wsum = 15'(15'd30 * 15'(r)) + 15'(15'd59 * 15'(g)) + 15'(15'd11 * 15'(b));
    prod = 28'(wsum) * 28'(RECIP_100);
    return prod[RECIP_SHIFT +: 8];
  endfunction

  // Glyph of a brightness band.
  function automatic logic [6:0] glyph_of(input logic [2:0] level);
    logic [6:0] code;
    case (level)
      3'd0: code = GLYPH_DOT;
      3'd1: code = GLYPH_COLON;
      3'd2: code = GLYPH_C;
      3'd3: code = GLYPH_O;
      3'd4: code = GLYPH_FIVE;
      3'd5: code = GLYPH_X;
      3'd6: code = GLYPH_HASH;
      default: code = GLYPH_AT;
    endcase
    return code;
  endfunction

endpackage

[design/gbag_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module gbag_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the entry being written sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/gbag_pos.sv]
// Raster position tracker: block counters, accumulator address and per-item flags.
`timescale 1ns / 1ps

module gbag_pos #(
  parameter int XW = 10,
  parameter int WW = 11,
  parameter int BW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  gbag_pkg::pixel_t  pixel,
  input  logic [WW-1:0]     width,
  input  logic [BW-1:0]     bsize,
  output gbag_pkg::stage_t  stage,
  output logic [XW-1:0]     addr
);

  localparam int CW = XW + 1;
  localparam int PW = XW + BW + 2;

  logic [XW-1:0] x_position;
  logic [BW-1:0] col_in_block;
  logic [XW-1:0] block_column;
  logic [BW-1:0] row_in_block;

  logic [XW-1:0] cur_x;
  logic [BW-1:0] cur_col;
  logic [XW-1:0] cur_bcol;
  logic [BW-1:0] cur_row;
  logic          last_col;
  logic          last_row;
  logic          row_wrap;
  logic [PW-1:0] block_end;
  logic [PW-1:0] next_end;
  logic          in_range;

  // A frame start moves the position back to the image origin before use.
  always_comb begin
    cur_x    = pixel.frame_start ? '0 : x_position;
    cur_col  = pixel.frame_start ? '0 : col_in_block;
    cur_bcol = pixel.frame_start ? '0 : block_column;
    cur_row  = pixel.frame_start ? '0 : row_in_block;
  end

  // Block edges; a counter at or past the block size wraps as at the block end.
  always_comb begin
    last_col  = (BW'(cur_col + 1'b1) >= bsize) || (&cur_col);
    last_row  = (BW'(cur_row + 1'b1) >= bsize) || (&cur_row);
    row_wrap  = (CW'(cur_x) + CW'(1)) >= CW'(width);
    block_end = PW'(PW'(cur_bcol) + PW'(1)) * PW'(bsize);
    next_end  = block_end + PW'(bsize);
    in_range  = block_end <= PW'(width);
  end

  // Flags and address of this item for the accumulator stage.
  always_comb begin
    stage.write   = in_range;
    stage.first   = (cur_row == '0) && (cur_col == '0);
    stage.emit    = in_range && last_col && last_row;
    stage.row_end = in_range && (next_end > PW'(width));
    stage.gray    = gbag_pkg::gray_of(pixel.red, pixel.green, pixel.blue);
    addr          = cur_bcol;
  end

  // Advance the raster position on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_position   <= '0;
      col_in_block <= '0;
      block_column <= '0;
      row_in_block <= '0;
    end else if (accept) begin
      if (row_wrap) begin
        x_position   <= '0;
        col_in_block <= '0;
        block_column <= '0;
        row_in_block <= last_row ? '0 : BW'(cur_row + 1'b1);
      end else begin
        x_position <= XW'(cur_x + 1'b1);
        row_in_block <= cur_row;
        if (last_col) begin
          col_in_block <= '0;
          block_column <= XW'(cur_bcol + 1'b1);
        end else begin
          col_in_block <= BW'(cur_col + 1'b1);
          block_column <= cur_bcol;
        end
      end
    end
  end

endmodule

[design/gbag_accum.sv]
// Accumulator stage: read-modify-write of a column sum, band quantizer and output register.
`timescale 1ns / 1ps

module gbag_accum #(
  parameter int AW = 10,
  parameter int BSQ_W = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  gbag_pkg::stage_t               stage,
  input  logic [AW-1:0]                  addr,
  input  logic [gbag_pkg::SUM_W-1:0]     rd_data,
  input  logic [BSQ_W-1:0]               bsq,
  output logic                           ready,
  output logic                           ram_we,
  output logic [AW-1:0]                  ram_waddr,
  output logic [gbag_pkg::SUM_W-1:0]     ram_wdata,
  output logic                           result_valid,
  input  logic                           result_ready,
  output gbag_pkg::result_t              result
);

  localparam int SW = gbag_pkg::SUM_W;
  localparam int TW = BSQ_W + 8;

  logic             s1_valid;
  gbag_pkg::stage_t s1;
  logic [AW-1:0]    s1_addr;
  logic             fwd_hit;
  logic [SW-1:0]    fwd_data;

  logic             s1_adv;
  logic [SW-1:0]    base;
  logic [SW-1:0]    sum;
  logic [2:0]       level;

  // The stage moves on unless its result finds the output register full.
  always_comb begin
    s1_adv = s1_valid && !(s1.emit && result_valid && !result_ready);
    ready  = !s1_valid || s1_adv;
  end

  // New column sum: the first pixel of a block starts it, a write just made is forwarded.
  always_comb begin
    if (s1.first) begin
      base = '0;
    end else if (fwd_hit) begin
      base = fwd_data;
    end else begin
      base = rd_data;
    end
    sum       = SW'(base + SW'(s1.gray));
    ram_we    = s1_adv && s1.write;
    ram_waddr = s1_addr;
    ram_wdata = sum;
  end

  // Band k is reached when the average is at least 32k+1, that is sum >= (32k+1) * b^2.
  always_comb begin
    level = '0;
    for (int k = 1; k < 8; k++) begin
      if (TW'(sum) >= TW'(TW'(32 * k + 1) * TW'(bsq))) begin
        level = 3'(level + 3'd1);
      end
    end
  end

  // Stage register, taken when an item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1       <= stage;
      s1_addr  <= addr;
      fwd_hit  <= ram_we && (s1_addr == addr);
      fwd_data <= sum;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (s1_adv && s1.emit) begin
      result.glyph   <= gbag_pkg::glyph_of(level);
      result.level   <= level;
      result.row_end <= s1.row_end;
    end
  end

`ifndef SYNTH
  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("output valid after reset");

  // Input stalls only behind a finished result that waits in a full output register.
  assert property (@(posedge clk) disable iff (rst)
    !ready |-> (s1_valid && s1.emit && result_valid))
    else $error("input stalled without a waiting result");

  // A write to the entry being read is forwarded to the next item.
  assert property (@(posedge clk) disable iff (rst)
    (accept && ram_we && (s1_addr == addr)) |=> fwd_hit)
    else $error("missed forwarding of a column sum");
`endif

endmodule

[design/gray_block_average_to_glyph_unit.sv]
// Top level of the gray block average to glyph unit: configuration registers and stage wiring.
// A result enters the output register when the stage holding the last pixel of its block moves on.
// Throughput: one pixel per cycle; the input stalls only while a finished result waits in a
// full output register. The column sum RAM is read at acceptance and written back when the
// stage moves on, with the fresh sum forwarded to a following pixel of the same column.
// Reset clears the raster position, stage and output valid; the column sums are not cleared.
`timescale 1ns / 1ps

module gray_block_average_to_glyph_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [gbag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbag_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  gbag_pkg::pixel_t                    pixel,
  output logic                                result_valid,
  input  logic                                result_ready,
  output gbag_pkg::result_t                   result
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int BW = $clog2(MAX_BLOCK + 1);
  localparam int BSQ_W = 2 * BW;
  localparam int RESET_WIDTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [WW-1:0]    width;
  logic [BW-1:0]    bsize;
  logic [BSQ_W-1:0] bsq;
  logic [WW-1:0]    width_new;
  logic [BW-1:0]    bsize_new;
  logic [3:0]       bs_raw;

  logic                         accept;
  gbag_pkg::stage_t             stage;
  logic [XW-1:0]                addr;
  logic                         ram_we;
  logic [XW-1:0]                ram_waddr;
  logic [gbag_pkg::SUM_W-1:0]   ram_wdata;
  logic [gbag_pkg::SUM_W-1:0]   rd_data;

  // Written values are clamped to the supported range as they are stored.
  always_comb begin
    bs_raw = cfg_data[3:0];
    if (cfg_data == '0) begin
      width_new = WW'(1);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      width_new = WW'(MAX_WIDTH);
    end else begin
      width_new = WW'(cfg_data);
    end
    if (bs_raw == '0) begin
      bsize_new = BW'(1);
    end else if (int'(bs_raw) > MAX_BLOCK) begin
      bsize_new = BW'(MAX_BLOCK);
    end else begin
      bsize_new = BW'(bs_raw);
    end
  end

  // Configuration registers, with the square of the block size kept alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      width <= WW'(RESET_WIDTH);
      bsize <= BW'(1);
      bsq   <= BSQ_W'(1);
    end else if (cfg_write_en) begin
      case (cfg_index)
        gbag_pkg::REG_IMAGE_WIDTH: begin
          width <= width_new;
        end
        gbag_pkg::REG_BLOCK_SIZE: begin
          bsize <= bsize_new;
          bsq   <= BSQ_W'(BSQ_W'(bsize_new) * BSQ_W'(bsize_new));
        end
        default: begin
        end
      endcase
    end
  end

  assign accept = pixel_valid && pixel_ready;

  gbag_pos #(
    .XW(XW),
    .WW(WW),
    .BW(BW)
  ) u_pos (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .pixel (pixel),
    .width (width),
    .bsize (bsize),
    .stage (stage),
    .addr  (addr)
  );

  gbag_ram #(
    .WIDTH(gbag_pkg::SUM_W),
    .DEPTH(MAX_WIDTH)
  ) u_sums (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(addr),
    .rdata(rd_data)
  );

  gbag_accum #(
    .AW(XW),
    .BSQ_W(BSQ_W)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stage       (stage),
    .addr        (addr),
    .rd_data     (rd_data),
    .bsq         (bsq),
    .ready       (pixel_ready),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule
